/* design/art_pkg.sv */
// art_pkg: shared types and codes for the address region table.
// Holds the transaction structs, status and command codes, the token that
// walks the cell chain and the control state type. No dependencies.
package art_pkg;

  localparam int MAX_REGIONS_DEF = 16;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_OVERLAP  = 3'd2;
  localparam logic [2:0] ST_UNMAPPED = 3'd3;
  localparam logic [2:0] ST_SPANS    = 3'd4;

  typedef struct packed {
    logic        cmd;
    logic [31:0] address;
    logic [31:0] length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  region_index;
    logic [31:0] region_offset;
    logic [31:0] first_part_length;
  } out_item_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic        cmd;
    logic [31:0] addr;
    logic [32:0] acc_end;
    logic        hit;
    logic [3:0]  hit_idx;
    logic [31:0] hit_off;
    logic        span;
    logic [3:0]  span_idx;
    logic [31:0] span_off;
    logic [31:0] span_first;
    logic        ovl;
  } tok_t;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

endpackage

/* design/art_cell.sv */
// art_cell: one region slot of the address region table chain.
// Stores one base and end, checks the passing token against them and
// registers the token for the next cell. Depends on art_pkg.
module art_cell #(
  parameter int IDX = 0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cell_vld,
  input  logic         wr_en,
  input  logic [31:0]  wr_base,
  input  logic [32:0]  wr_end,
  input  logic         vld_in,
  input  art_pkg::tok_t tok_in,
  output logic         vld_out,
  output art_pkg::tok_t tok_out
);
  import art_pkg::*;

  logic [31:0] base_r;
  logic [32:0] end_r;
  logic        vld_r;
  tok_t        tok_r;
  tok_t        tok_nxt;
  logic        base_le;
  logic        cov_end;
  logic        in_reg;
  logic        ovl_hit;

  always_comb begin
    tok_nxt = tok_in;
    base_le = base_r <= tok_in.addr;
    cov_end = tok_in.acc_end <= end_r;
    in_reg  = {1'b0, tok_in.addr} < end_r;
    ovl_hit = in_reg && ({1'b0, base_r} < tok_in.acc_end);
    if (cell_vld) begin
      // lowest index wins a full hit
      if (!tok_in.hit && base_le && cov_end) begin
        tok_nxt.hit     = 1'b1;
        tok_nxt.hit_idx = 4'(IDX);
        tok_nxt.hit_off = tok_in.addr - base_r;
      end
      // highest index wins the start-address match
      if (base_le && in_reg) begin
        tok_nxt.span       = 1'b1;
        tok_nxt.span_idx   = 4'(IDX);
        tok_nxt.span_off   = tok_in.addr - base_r;
        tok_nxt.span_first = 32'(end_r - {1'b0, tok_in.addr});
      end
      if (ovl_hit) begin
        tok_nxt.ovl = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      base_r <= wr_base;
      end_r  <= wr_end;
    end
    tok_r <= tok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  assign vld_out = vld_r;
  assign tok_out = tok_r;

endmodule

/* design/address_region_table.sv */
// address_region_table: top level of the region table with add and lookup.
// Builds a chain of art_cell slots, the control state and the result
// registers. Depends on art_pkg and art_cell.
//
//   channel | ports                       | payload     | direction
//   --------+-----------------------------+-------------+----------
//   input   | in_valid, in_stall, in_data  | in_item_t   | in
//   result  | out_valid, out_stall, out_data| out_item_t | out
//
// Cycles: one transaction walks the chain of MAX_REGIONS cells, one cell a
//   cycle; its result is registered in the output or hold register once it
//   leaves the last cell, and the next transaction is taken only after it
//   has left the chain, so one transaction is in the chain at a time.
// Reset: clears the region count, the chain valid bits, the output and hold
//   valid bits and the control state; region storage is not cleared and
//   only slots below the count are ever consulted.
// Stalls: a finished result waits in the output register and a second one
//   in a hold register, so a new transaction is taken while out_stall is
//   high; input stalls only while a transaction is in the chain or the
//   hold register is full.
module address_region_table #(
  parameter int MAX_REGIONS = art_pkg::MAX_REGIONS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  art_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output art_pkg::out_item_t out_data
);
  import art_pkg::*;

  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  state_t             state_r;
  state_t             state_nxt;
  logic               in_acc;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  tok_t               tok [MAX_REGIONS+1];
  logic [MAX_REGIONS:0] vld;
  logic [MAX_REGIONS-1:0] cell_vld;
  logic [MAX_REGIONS-1:0] wr_en;

  tok_t               tail;
  logic               tail_vld;
  logic               add_ok;
  out_item_t          res;

  logic               out_vld_r;
  logic               out_vld_nxt;
  out_item_t          out_r;
  out_item_t          out_nxt;
  logic               hold_vld_r;
  logic               hold_vld_nxt;
  out_item_t          hold_r;
  out_item_t          hold_nxt;
  logic               out_take;

  // Control: one transaction in the chain at a time.
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = hold_vld_r;
        if (in_valid && !hold_vld_r) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (tail_vld) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Launch the token: start address, 33-bit access end, no matches yet.
  always_comb begin
    tok[0]         = '0;
    tok[0].cmd     = in_data.cmd;
    tok[0].addr    = in_data.address;
    tok[0].acc_end = {1'b0, in_data.address} + {1'b0, in_data.length};
  end
  assign vld[0] = in_acc;

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    assign cell_vld[i] = CNT_W'(i) < count_r;
    assign wr_en[i]    = tail_vld && add_ok && (count_r == CNT_W'(i));

    art_cell #(
      .IDX(i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_vld(cell_vld[i]),
      .wr_en   (wr_en[i]),
      .wr_base (tail.addr),
      .wr_end  (tail.acc_end),
      .vld_in  (vld[i]),
      .tok_in  (tok[i]),
      .vld_out (vld[i+1]),
      .tok_out (tok[i+1])
    );
  end

  assign tail     = tok[MAX_REGIONS];
  assign tail_vld = vld[MAX_REGIONS];

  // Resolve the token that left the last cell.
  always_comb begin
    res       = '0;
    add_ok    = 1'b0;
    count_nxt = count_r;
    if (tail.cmd == CMD_ADD) begin
      if (tail.acc_end == {1'b0, tail.addr}) begin
        // zero-size add: accept and drop
        res.status = ST_OK;
      end else if (count_r == CNT_W'(MAX_REGIONS)) begin
        res.status = ST_FULL;
      end else if (tail.ovl) begin
        res.status = ST_OVERLAP;
      end else begin
        res.status       = ST_OK;
        res.region_index = 4'(count_r);
        add_ok           = 1'b1;
      end
    end else begin
      if (tail.hit) begin
        res.status        = ST_OK;
        res.region_index  = tail.hit_idx;
        res.region_offset = tail.hit_off;
      end else if (tail.span) begin
        res.status            = ST_SPANS;
        res.region_index      = tail.span_idx;
        res.region_offset     = tail.span_off;
        res.first_part_length = tail.span_first;
      end else begin
        res.status = ST_UNMAPPED;
      end
    end
    if (tail_vld && add_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  // Output register plus hold slot; drain hold into output when taken.
  always_comb begin
    out_take     = out_vld_r && !out_stall;
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    hold_vld_nxt = hold_vld_r;
    hold_nxt     = hold_r;
    if (tail_vld) begin
      if (!out_vld_r || out_take) begin
        out_vld_nxt = 1'b1;
        out_nxt     = res;
      end else begin
        hold_vld_nxt = 1'b1;
        hold_nxt     = res;
      end
    end else if (out_take) begin
      if (hold_vld_r) begin
        out_nxt      = hold_r;
        hold_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      hold_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      hold_vld_r <= hold_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    hold_r <= hold_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // At most one token in flight along the chain.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(vld))
    else $error("more than one token in the cell chain");

  // A finished token never meets a full hold slot.
  a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    tail_vld |-> !hold_vld_r)
    else $error("result arrived with hold slot occupied");

  // Writes only go to a free slot and the count stays in range.
  a_wr_free: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en & cell_vld) == '0 && count_r <= CNT_W'(MAX_REGIONS))
    else $error("region write into a used slot or count overflow");

  // Hold slot is only used behind a waiting output.
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    hold_vld_r |-> out_vld_r)
    else $error("hold slot valid with empty output register");

endmodule
